@@ src/mfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfs_pkg: shared constants and types of the Manchester frame serializer
// Stream geometry, word packing constants and the frame type shared by the
// front stage, the frame queue and the serializer.
// ----------------------------------------------------------------------------
package mfs_pkg;

  // Frame and packing geometry
  localparam int HALF_BITS      = 40;
  localparam int FRAME_BITS     = 2 * HALF_BITS;
  localparam int FRAME_IDX_W    = $clog2(FRAME_BITS);
  localparam int WORD_BITS      = 16;
  localparam int PREAMBLE_PAIRS = 128;

  // Stream layout in symbols
  localparam int PAYLOAD_SYMS = 2 * FRAME_BITS;
  localparam int GAP_A        = 4;
  localparam int GAP_B        = 8;
  localparam int PRE_SYMS     = 2 * PREAMBLE_PAIRS;
  localparam int PAY1_START   = PRE_SYMS + GAP_A;
  localparam int GAP2_START   = PAY1_START + PAYLOAD_SYMS;
  localparam int PAY2_START   = GAP2_START + GAP_B;
  localparam int TOTAL_SYMS   = PAY2_START + PAYLOAD_SYMS;

  // Word packing
  localparam int NUM_WORDS  = (TOTAL_SYMS + WORD_BITS - 1) / WORD_BITS;
  localparam int LAST_POS   = (NUM_WORDS - 1) * WORD_BITS;
  localparam int LAST_COUNT = TOTAL_SYMS - LAST_POS;
  localparam int SYM_W      = $clog2(NUM_WORDS * WORD_BITS);
  localparam int CNT_W      = 5;

  // Frame queue depth
  localparam int QUEUE_DEPTH = 2;

  typedef logic [HALF_BITS-1:0]  half_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [CNT_W-1:0]      count_t;

endpackage

@@ src/mfs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfs_front: frame intake and check insertion
// Accepts one frame beat, replaces the low nibble of byte 9 with the 4-bit
// check and holds the result until the frame queue takes it.
// ----------------------------------------------------------------------------
module mfs_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           frame_valid,
  output logic                frame_ready,
  input  wire mfs_pkg::half_t first_half,
  input  wire mfs_pkg::half_t second_half,
  output logic                push_valid,
  input  wire logic           push_ready,
  output mfs_pkg::frame_t     push_frame
);
  import mfs_pkg::*;

  logic   stage_valid;
  frame_t stage_frame;
  logic   [3:0] check;
  logic   take;

  // Fold all nibbles except the incoming check nibble, then add one
  always_comb begin
    logic [3:0] acc;
    acc = 4'h0;
    for (int i = 0; i < HALF_BITS / 4; i++) begin
      acc = acc ^ first_half[4*i +: 4];
    end
    for (int i = 1; i < HALF_BITS / 4; i++) begin
      acc = acc ^ second_half[4*i +: 4];
    end
    check = acc + 4'h1;
  end

  assign frame_ready = !stage_valid || push_ready;
  assign take        = frame_valid && frame_ready;

  // Hold the checked frame until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_frame <= {first_half, second_half[HALF_BITS-1:4], check};
    end
  end

  assign push_valid = stage_valid;
  assign push_frame = stage_frame;

endmodule
`default_nettype wire

@@ src/mfs_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfs_queue: checked-frame queue
// Small FIFO of checked frames between the intake stage and the serializer,
// so that each side can stall on its own.
// ----------------------------------------------------------------------------
module mfs_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire mfs_pkg::frame_t push_frame,
  output logic                 pop_valid,
  input  wire logic            pop,
  output mfs_pkg::frame_t      head_frame
);
  import mfs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  frame_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != FILL_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign head_frame = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  // Store pushed frames
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_frame;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(QUEUE_DEPTH))
    else $error("frame queue overfilled");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (fill == $past(fill) - FILL_W'(1)))
    else $error("frame queue fill did not drop on pop");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (wr_ptr == rd_ptr))
    else $error("frame queue pointers differ while empty");
`endif

endmodule
`default_nettype wire

@@ src/mfs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfs_back: symbol stream serializer
// Walks the queue head's symbol stream one word per cycle unless stalled,
// building each word lane by lane, and holds it in the output register.
// ----------------------------------------------------------------------------
module mfs_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire mfs_pkg::frame_t head_frame,
  output logic                 head_pop,
  output logic                 word_valid,
  input  wire logic            word_ready,
  output mfs_pkg::word_t       symbol_word,
  output mfs_pkg::count_t      symbol_count,
  output logic                 last_word
);
  import mfs_pkg::*;

  logic [SYM_W-1:0] pos;
  logic             advance;
  logic             at_last;
  word_t            word_next;

  // Symbol value at stream position s
  function automatic logic sym_at(input logic [SYM_W-1:0] s, input frame_t f);
    logic [SYM_W-1:0]       off;
    logic [FRAME_IDX_W-1:0] bidx;
    logic                   res;
    off  = '0;
    bidx = '0;
    res  = 1'b0;
    if (s < SYM_W'(PRE_SYMS)) begin
      res = s[0];
    end else if (s < SYM_W'(PAY1_START)) begin
      res = 1'b0;
    end else if (s < SYM_W'(GAP2_START)) begin
      off  = s - SYM_W'(PAY1_START);
      bidx = off[FRAME_IDX_W:1];
      res  = f[FRAME_IDX_W'(FRAME_BITS - 1) - bidx] ^ off[0];
    end else if (s < SYM_W'(PAY2_START)) begin
      res = 1'b0;
    end else if (s < SYM_W'(TOTAL_SYMS)) begin
      off  = s - SYM_W'(PAY2_START);
      bidx = off[FRAME_IDX_W:1];
      res  = f[FRAME_IDX_W'(FRAME_BITS - 1) - bidx] ^ off[0];
    end
    return res;
  endfunction

  // Build the next word, one lane per symbol slot
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      word_next[WORD_BITS-1-i] = sym_at(pos + SYM_W'(i), head_frame);
    end
  end

  assign at_last  = (pos == SYM_W'(LAST_POS));
  assign advance  = head_valid && (!word_valid || word_ready);
  assign head_pop = advance && at_last;

  // Advance the stream position, wrap after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (advance) begin
      pos <= at_last ? '0 : pos + SYM_W'(WORD_BITS);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (advance) begin
      word_valid <= 1'b1;
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      symbol_word  <= word_next;
      symbol_count <= at_last ? CNT_W'(LAST_COUNT) : CNT_W'(WORD_BITS);
      last_word    <= at_last;
    end
  end

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= SYM_W'(LAST_POS))
    else $error("stream position past last word");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (advance && at_last) |=> (pos == '0))
    else $error("stream position did not wrap after last word");

  a_last_count: assert property (@(posedge clk) disable iff (rst)
    (word_valid && last_word) |-> (symbol_count == CNT_W'(LAST_COUNT)))
    else $error("final word carries wrong symbol count");
`endif

endmodule
`default_nettype wire

@@ src/manchester_frame_serializer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// manchester_frame_serializer: Manchester frame serializer with preamble
// Inserts a 4-bit check into each 80-bit frame and emits the preamble, gaps
// and twice-sent Manchester-coded payload as 16-symbol words.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------------
//  frame   | frame_valid, frame_ready | first_half[39:0], second_half[39:0]
//  word    | word_valid, word_ready   | symbol_word[15:0], symbol_count[4:0],
//          |                          | last_word
//
//  Each frame yields 37 word beats, one per cycle when word_ready is high.
//  After the intake stage takes a frame, its first word passes the queue
//  write and then the output register before it is valid. Up to two checked
//  frames wait in the queue plus one in the intake stage. A low word_ready
//  holds the current word and stalls the serializer; frames keep entering
//  until the queue is full. rst is synchronous and clears all valid flags
//  and the stream position.
// ----------------------------------------------------------------------------
module manchester_frame_serializer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           frame_valid,
  output logic                frame_ready,
  input  wire mfs_pkg::half_t first_half,
  input  wire mfs_pkg::half_t second_half,
  output logic                word_valid,
  input  wire logic           word_ready,
  output mfs_pkg::word_t      symbol_word,
  output mfs_pkg::count_t     symbol_count,
  output logic                last_word
);
  import mfs_pkg::*;

  logic   push_valid;
  logic   push_ready;
  frame_t push_frame;
  logic   head_valid;
  logic   head_pop;
  frame_t head_frame;

  // Intake and check insertion
  mfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .first_half  (first_half),
    .second_half (second_half),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_frame  (push_frame)
  );

  // Decoupling queue
  mfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .pop_valid  (head_valid),
    .pop        (head_pop),
    .head_frame (head_frame)
  );

  // Serializer and output register
  mfs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_frame   (head_frame),
    .head_pop     (head_pop),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .symbol_word  (symbol_word),
    .symbol_count (symbol_count),
    .last_word    (last_word)
  );

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for manchester_frame_serializer
// Drives 80-bit frames over the frame channel and checks every word beat
// against a stream built locally: inserted check nibble, preamble, gaps and
// the payload Manchester coded twice. Directed frames hit the data extremes,
// the check wrap cases, back-to-back frames and a full queue under a long
// word stall. A long random run follows. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;

  // Line stream layout, in symbols
  localparam int SYMS_PER_WORD = 16;
  localparam int PREAMBLE_END  = 2 * 128;
  localparam int PAY1_BEGIN    = PREAMBLE_END + 4;
  localparam int PAY1_END      = PAY1_BEGIN + 160;
  localparam int PAY2_BEGIN    = PAY1_END + 8;
  localparam int STREAM_END    = PAY2_BEGIN + 160;

  localparam int STALL_LIMIT   = 2000;  // cycles with no beat at all
  localparam int DRAIN_CYCLES  = 20;

  typedef struct packed {
    mfs_pkg::word_t  word;
    mfs_pkg::count_t count;
    logic            last;
  } line_word_t;

  logic            clk          = 1'b0;
  logic            rst          = 1'b1;
  logic            frame_valid  = 1'b0;
  logic            frame_ready;
  mfs_pkg::half_t  first_half   = '0;
  mfs_pkg::half_t  second_half  = '0;
  logic            word_valid;
  logic            word_ready   = 1'b0;
  mfs_pkg::word_t  symbol_word;
  mfs_pkg::count_t symbol_count;
  logic            last_word;

  line_word_t expected_words[$];
  int         mismatches     = 0;
  int         frame_gap_pct  = 10;
  int         word_stall_pct = 10;
  int         hold_request   = 0;
  int         hold_left      = 0;
  int         quiet_cycles   = 0;

  manchester_frame_serializer u_dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .first_half   (first_half),
    .second_half  (second_half),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .symbol_word  (symbol_word),
    .symbol_count (symbol_count),
    .last_word    (last_word)
  );

  always #1 clk = ~clk;

  // Build the full word stream of one frame and queue it
  function automatic void queue_frame_stream(input mfs_pkg::half_t hi,
                                             input mfs_pkg::half_t lo);
    logic [79:0] frame;
    logic [3:0]  chk;
    line_word_t  w;
    int          pos;
    int          s;
    int          off;
    logic        sym;
    chk = 4'h0;
    for (int i = 0; i < 10; i++) chk ^= hi[4*i +: 4];
    for (int i = 1; i < 10; i++) chk ^= lo[4*i +: 4];
    chk   = chk + 4'd1;
    frame = {hi, lo[39:4], chk};
    pos   = 0;
    while (pos < STREAM_END) begin
      w = '0;
      for (int i = 0; i < SYMS_PER_WORD; i++) begin
        s = pos + i;
        if (s < STREAM_END) begin
          if (s < PREAMBLE_END) begin
            sym = s[0];
          end else if (s < PAY1_BEGIN) begin
            sym = 1'b0;
          end else if (s < PAY1_END) begin
            off = s - PAY1_BEGIN;
            sym = frame[79 - (off >> 1)] ^ off[0];
          end else if (s < PAY2_BEGIN) begin
            sym = 1'b0;
          end else begin
            off = s - PAY2_BEGIN;
            sym = frame[79 - (off >> 1)] ^ off[0];
          end
          w.word[SYMS_PER_WORD-1-i] = sym;
          w.count = w.count + 1'b1;
        end
      end
      pos    = pos + w.count;
      w.last = (pos >= STREAM_END);
      expected_words.push_back(w);
    end
  endfunction

  function automatic mfs_pkg::half_t rand_half();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[39:0];
  endfunction

  // Offer one frame beat; valid stays up after acceptance for the next call
  task automatic send_frame(input mfs_pkg::half_t hi, input mfs_pkg::half_t lo);
    while ($urandom_range(99) < frame_gap_pct) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    first_half  <= hi;
    second_half <= lo;
    do @(posedge clk); while (!frame_ready);
    queue_frame_stream(hi, lo);
  endtask

  // Drop valid and wait until every queued word has come out
  task automatic wait_drained();
    frame_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic test_field_extremes();
    send_frame('0, '0);
    send_frame('1, '1);
    send_frame('0, '1);
    send_frame('1, '0);
    send_frame(40'hAA_AAAA_AAAA, 40'h55_5555_5555);
    send_frame(40'h55_5555_5555, 40'hAA_AAAA_AAAA);
    send_frame(40'h80_0000_0001, 40'h80_0000_0010);
    wait_drained();
  endtask

  // Incoming low nibble is ignored; check wraps to zero and reaches F
  task automatic test_check_nibble();
    send_frame(40'h12_3456_789A, 40'hBC_DEF0_1230);
    send_frame(40'h12_3456_789A, 40'hBC_DEF0_123F);
    send_frame('0, 40'h00_0000_00F5);
    send_frame('0, 40'h00_0000_00EA);
    wait_drained();
  endtask

  // Frames with no gap and no stall, stream after stream
  task automatic test_back_to_back();
    frame_gap_pct  = 0;
    word_stall_pct = 0;
    repeat (5) send_frame(rand_half(), rand_half());
    wait_drained();
    frame_gap_pct  = 10;
    word_stall_pct = 10;
  endtask

  // Hold the word side off long enough for the frame queue to fill
  task automatic test_queue_fill();
    frame_gap_pct = 0;
    @(negedge clk);
    hold_request = 300;
    @(posedge clk);
    repeat (6) send_frame(rand_half(), rand_half());
    wait_drained();
    frame_gap_pct = 10;
  endtask

  task automatic test_random_frames();
    mfs_pkg::half_t hi;
    mfs_pkg::half_t lo;
    for (int n = 0; n < 350; n++) begin
      // middle stretch runs with no idling on either side
      frame_gap_pct  = (n >= 120 && n < 230) ? 0 : 10;
      word_stall_pct = frame_gap_pct;
      hi = rand_half();
      lo = rand_half();
      if ($urandom_range(4) == 0) begin
        // byte-filled frames push the check toward its corners
        for (int b = 0; b < 5; b++) begin
          hi[8*b +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
          lo[8*b +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
      end
      send_frame(hi, lo);
    end
    wait_drained();
  endtask

  // Word sink: drive ready, check each word beat against the queue
  always @(posedge clk) begin : word_sink
    line_word_t want;
    if (!rst && word_valid && word_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word beat: word=%h count=%0d last=%b",
                 $time, symbol_word, symbol_count, last_word);
      end else begin
        want = expected_words.pop_front();
        if (symbol_word !== want.word) begin
          mismatches++;
          $display("%0t: symbol_word expected %h actual %h",
                   $time, want.word, symbol_word);
        end
        if (symbol_count !== want.count) begin
          mismatches++;
          $display("%0t: symbol_count expected %0d actual %0d",
                   $time, want.count, symbol_count);
        end
        if (last_word !== want.last) begin
          mismatches++;
          $display("%0t: last_word expected %b actual %b",
                   $time, want.last, last_word);
        end
      end
    end
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      word_ready <= 1'b0;
    end else begin
      word_ready <= ($urandom_range(99) >= word_stall_pct);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((frame_valid && frame_ready) || (word_valid && word_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("manchester_frame_serializer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_check_nibble();
    test_back_to_back();
    test_queue_fill();
    test_random_frames();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("manchester_frame_serializer test passed");
    end else begin
      $display("manchester_frame_serializer test failed");
    end
    $finish;
  end

endmodule
